// File: rtl/pidc_pkg.sv
package pidc_pkg;

   localparam int unsigned DATA_W  = 16;               // Q8.8 word width
   localparam int unsigned DIFF_W  = DATA_W + 1;       // error / derivative
   localparam int unsigned ISUM_W  = DATA_W + 2;       // integrator + error
   localparam int unsigned PROD_W  = 2 * DIFF_W;       // one gain product
   localparam int unsigned ACC_W   = PROD_W + 2;       // sum of three products
   localparam int unsigned FRAC_W  = 8;
   localparam int unsigned CLAMP_W = ACC_W - FRAC_W;   // rounded drive, pre-clamp
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned ROUND_BIAS = 1 << (FRAC_W - 1);

   // register indexes
   localparam logic [IDX_W-1:0] REG_SETPOINT    = 3'd0;
   localparam logic [IDX_W-1:0] REG_GAIN_P      = 3'd1;
   localparam logic [IDX_W-1:0] REG_GAIN_I      = 3'd2;
   localparam logic [IDX_W-1:0] REG_GAIN_D      = 3'd3;
   localparam logic [IDX_W-1:0] REG_INTEG_UPPER = 3'd4;
   localparam logic [IDX_W-1:0] REG_INTEG_LOWER = 3'd5;
   localparam logic [IDX_W-1:0] REG_DRIVE_UPPER = 3'd6;
   localparam logic [IDX_W-1:0] REG_DRIVE_LOWER = 3'd7;

   // reset values
   localparam logic [DATA_W-1:0] SETPOINT_RST    = 16'd25600;  // 100.0
   localparam logic [DATA_W-1:0] GAIN_P_RST      = 16'd13;     // ~0.05
   localparam logic [DATA_W-1:0] GAIN_I_RST      = 16'd256;    // 1.0
   localparam logic [DATA_W-1:0] GAIN_D_RST      = 16'd640;    // 2.5
   localparam logic [DATA_W-1:0] INTEG_UPPER_RST = 16'd1280;   // 5.0
   localparam logic [DATA_W-1:0] INTEG_LOWER_RST = 16'hFB00;   // -5.0
   localparam logic [DATA_W-1:0] DRIVE_UPPER_RST = 16'd2560;   // 10.0
   localparam logic [DATA_W-1:0] DRIVE_LOWER_RST = 16'd0;      // 0.0

   typedef struct packed {
      logic [DATA_W-1:0] setpoint;
      logic [DATA_W-1:0] gain_p;
      logic [DATA_W-1:0] gain_i;
      logic [DATA_W-1:0] gain_d;
      logic [DATA_W-1:0] integ_upper;
      logic [DATA_W-1:0] integ_lower;
      logic [DATA_W-1:0] drive_upper;
      logic [DATA_W-1:0] drive_lower;
   } cfg_type;

   // error/integrator stage -> multiply stage
   typedef struct packed {
      logic [DIFF_W-1:0] err;
      logic [DIFF_W-1:0] deriv;
      logic [DATA_W-1:0] integ;
      logic              integ_hit;
   } front_type;

   // multiply stage -> output stage
   typedef struct packed {
      logic [PROD_W-1:0] prod_p;
      logic [PROD_W-1:0] prod_i;
      logic [PROD_W-1:0] prod_d;
      logic              integ_hit;
   } prod_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              hit;
   } clamp_type;

   // upper bound first, then lower bound against the result
   function automatic clamp_type clamp_q88(input logic signed [CLAMP_W-1:0] v,
                                           input logic signed [DATA_W-1:0]  hi,
                                           input logic signed [DATA_W-1:0]  lo);
      clamp_type                  res;
      logic signed [CLAMP_W-1:0]  t;
      t       = v;
      res.hit = 1'b0;
      if (t > hi) begin
         t       = CLAMP_W'(hi);
         res.hit = 1'b1;
      end
      if (t < lo) begin
         t       = CLAMP_W'(lo);
         res.hit = 1'b1;
      end
      res.value = t[DATA_W-1:0];
      return res;
   endfunction

endpackage

// File: rtl/pidc_csr.sv
module pidc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wen,
   input  logic [pidc_pkg::IDX_W-1:0]   csr_index,
   input  logic [pidc_pkg::DATA_W-1:0]  csr_wdata,
   output pidc_pkg::cfg_type            cfg
);

   pidc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint    <= pidc_pkg::SETPOINT_RST;
         cfg_ff.gain_p      <= pidc_pkg::GAIN_P_RST;
         cfg_ff.gain_i      <= pidc_pkg::GAIN_I_RST;
         cfg_ff.gain_d      <= pidc_pkg::GAIN_D_RST;
         cfg_ff.integ_upper <= pidc_pkg::INTEG_UPPER_RST;
         cfg_ff.integ_lower <= pidc_pkg::INTEG_LOWER_RST;
         cfg_ff.drive_upper <= pidc_pkg::DRIVE_UPPER_RST;
         cfg_ff.drive_lower <= pidc_pkg::DRIVE_LOWER_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            pidc_pkg::REG_SETPOINT:    cfg_ff.setpoint    <= csr_wdata;
            pidc_pkg::REG_GAIN_P:      cfg_ff.gain_p      <= csr_wdata;
            pidc_pkg::REG_GAIN_I:      cfg_ff.gain_i      <= csr_wdata;
            pidc_pkg::REG_GAIN_D:      cfg_ff.gain_d      <= csr_wdata;
            pidc_pkg::REG_INTEG_UPPER: cfg_ff.integ_upper <= csr_wdata;
            pidc_pkg::REG_INTEG_LOWER: cfg_ff.integ_lower <= csr_wdata;
            pidc_pkg::REG_DRIVE_UPPER: cfg_ff.drive_upper <= csr_wdata;
            pidc_pkg::REG_DRIVE_LOWER: cfg_ff.drive_lower <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/pidc_front.sv
// Error, derivative and clamped integrator. Holds the loop state; the state
// moves exactly when a word passes into this stage.
module pidc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  pidc_pkg::cfg_type            cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [pidc_pkg::DATA_W-1:0]  in_meas,
   output logic                         out_valid,
   input  logic                         out_ready,
   output pidc_pkg::front_type          out_data
);

   logic                          valid_ff;
   pidc_pkg::front_type           data_ff;
   pidc_pkg::front_type           data_in;
   logic [pidc_pkg::DATA_W-1:0]   integ_ff;
   logic [pidc_pkg::DATA_W-1:0]   prev_ff;
   logic [pidc_pkg::ISUM_W-1:0]   isum;
   pidc_pkg::clamp_type           iclamp;
   logic                          take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      data_in.err   = {cfg.setpoint[pidc_pkg::DATA_W-1], cfg.setpoint}
                    - {in_meas[pidc_pkg::DATA_W-1], in_meas};
      data_in.deriv = {in_meas[pidc_pkg::DATA_W-1], in_meas}
                    - {prev_ff[pidc_pkg::DATA_W-1], prev_ff};
      isum          = {{2{integ_ff[pidc_pkg::DATA_W-1]}}, integ_ff}
                    + {data_in.err[pidc_pkg::DIFF_W-1], data_in.err};
      iclamp        = pidc_pkg::clamp_q88(
                         {{(pidc_pkg::CLAMP_W - pidc_pkg::ISUM_W){isum[pidc_pkg::ISUM_W-1]}},
                          isum},
                         cfg.integ_upper, cfg.integ_lower);
      data_in.integ     = iclamp.value;
      data_in.integ_hit = iclamp.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         integ_ff <= '0;
         prev_ff  <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (take) begin
            integ_ff <= data_in.integ;
            prev_ff  <= in_meas;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

`ifndef SYNTH
   // with sane bounds the stored integrator never leaves them
   a_integ_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (take && ($signed(cfg.integ_lower) <= $signed(cfg.integ_upper)))
      |=> (($signed(integ_ff) <= $signed($past(cfg.integ_upper)))
           && ($signed(integ_ff) >= $signed($past(cfg.integ_lower)))))
      else $error("integrator outside its clamp bounds");
   // a clamped integrator sits on one of the bounds
   a_integ_hit_bound: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff.integ_hit)
      |-> ((data_ff.integ == cfg.integ_upper) || (data_ff.integ == cfg.integ_lower)))
      else $error("integrator clamp flag without a bound value");
   // the stage word and the stored integrator agree
   a_integ_state: assert property (@(posedge clock) disable iff (reset)
      take |=> (integ_ff == data_ff.integ))
      else $error("integrator state and stage word disagree");
`endif

endmodule

// File: rtl/pidc_mult.sv
// Three gain products, one registered stage.
module pidc_mult (
   input  logic                  clock,
   input  logic                  reset,
   input  pidc_pkg::cfg_type     cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pidc_pkg::front_type   in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pidc_pkg::prod_type    out_data
);

   logic                               valid_ff;
   pidc_pkg::prod_type                 data_ff;
   pidc_pkg::prod_type                 data_in;
   logic signed [pidc_pkg::DIFF_W-1:0] gain_p_s;
   logic signed [pidc_pkg::DIFF_W-1:0] gain_i_s;
   logic signed [pidc_pkg::DIFF_W-1:0] gain_d_s;
   logic signed [pidc_pkg::DIFF_W-1:0] err_s;
   logic signed [pidc_pkg::DIFF_W-1:0] deriv_s;
   logic signed [pidc_pkg::DATA_W-1:0] integ_s;
   logic signed [pidc_pkg::PROD_W-1:0] prod_p;
   logic signed [pidc_pkg::PROD_W-1:0] prod_i;
   logic signed [pidc_pkg::PROD_W-1:0] prod_d;

   assign in_ready = !valid_ff || out_ready;

   // gains are unsigned: zero-extend into the signed multiplier
   assign gain_p_s = {1'b0, cfg.gain_p};
   assign gain_i_s = {1'b0, cfg.gain_i};
   assign gain_d_s = {1'b0, cfg.gain_d};
   assign err_s    = in_data.err;
   assign deriv_s  = in_data.deriv;
   assign integ_s  = in_data.integ;

   assign prod_p = gain_p_s * err_s;
   assign prod_i = gain_i_s * integ_s;
   assign prod_d = gain_d_s * deriv_s;

   always_comb begin
      data_in.prod_p    = prod_p;
      data_in.prod_i    = prod_i;
      data_in.prod_d    = prod_d;
      data_in.integ_hit = in_data.integ_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/pidc_out.sv
// Sum, round to Q8.8, clamp, and the result register facing the receiver.
module pidc_out (
   input  logic                         clock,
   input  logic                         reset,
   input  pidc_pkg::cfg_type            cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  pidc_pkg::prod_type           in_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pidc_pkg::DATA_W-1:0]  rsp_drive,
   output logic                         rsp_integ_clamped,
   output logic                         rsp_drive_clamped
);

   logic                                valid_ff;
   logic [pidc_pkg::DATA_W-1:0]         drive_ff;
   logic                                integ_hit_ff;
   logic                                drive_hit_ff;
   logic signed [pidc_pkg::PROD_W-1:0]  prod_p;
   logic signed [pidc_pkg::PROD_W-1:0]  prod_i;
   logic signed [pidc_pkg::PROD_W-1:0]  prod_d;
   logic signed [pidc_pkg::ACC_W-1:0]   acc;
   pidc_pkg::clamp_type                 dclamp;

   assign in_ready = !valid_ff || !rsp_stall;

   assign prod_p = in_data.prod_p;
   assign prod_i = in_data.prod_i;
   assign prod_d = in_data.prod_d;

   // Q20.16 sum plus half an LSB; dropping the low byte floors the division
   assign acc = pidc_pkg::ACC_W'(prod_p) + pidc_pkg::ACC_W'(prod_i)
              - pidc_pkg::ACC_W'(prod_d) + pidc_pkg::ACC_W'(pidc_pkg::ROUND_BIAS);

   assign dclamp = pidc_pkg::clamp_q88(acc[pidc_pkg::ACC_W-1:pidc_pkg::FRAC_W],
                                       cfg.drive_upper, cfg.drive_lower);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         drive_ff     <= dclamp.value;
         integ_hit_ff <= in_data.integ_hit;
         drive_hit_ff <= dclamp.hit;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_drive         = drive_ff;
   assign rsp_integ_clamped = integ_hit_ff;
   assign rsp_drive_clamped = drive_hit_ff;

`ifndef SYNTH
   // an unclamped drive lies between the bounds
   a_drive_unclamped: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && !dclamp.hit)
      |=> (($signed(drive_ff) <= $signed($past(cfg.drive_upper)))
           && ($signed(drive_ff) >= $signed($past(cfg.drive_lower)))))
      else $error("unclamped drive outside the output range");
   // a clamped drive sits on one of the bounds
   a_drive_hit_bound: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && dclamp.hit)
      |=> ((drive_ff == $past(cfg.drive_upper)) || (drive_ff == $past(cfg.drive_lower))))
      else $error("drive clamp flag without a bound value");
`endif

endmodule

// File: rtl/pid_controller_clamped.sv
// PID regulator with clamped integrator and clamped drive, Q8.8 throughout.
//
// Input channel (req_): one measured position word per accept, taken at a
// rising edge with req_valid high and req_stall low.
// Result channel (rsp_): drive plus integrator / drive clamp flags, one word
// per input word, in order, handed over when rsp_valid is high and
// rsp_stall low.
// Config port (csr_): csr_wen writes csr_wdata into register csr_index at the
// clock edge (setpoint, three gains, integrator and drive bounds). Write
// only while no word is in flight.
//
// Pipeline: input register, error/integrator stage, multiply stage, result
// register. rsp_valid rises once the word reaches the result register; one
// word is taken every cycle while no stall on rsp_ backs up the pipe.
// A stall on rsp_ holds the result register; each stage keeps taking words
// while it has a free slot, so req_stall only rises once the pipe is full.
// Reset (synchronous) empties the pipe, zeroes integrator and previous
// sample, and loads the register defaults.
module pid_controller_clamped (
   input  logic                         clock,
   input  logic                         reset,
   // config
   input  logic                         csr_wen,
   input  logic [pidc_pkg::IDX_W-1:0]   csr_index,
   input  logic [pidc_pkg::DATA_W-1:0]  csr_wdata,
   // input samples
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pidc_pkg::DATA_W-1:0]  req_measured_position,
   // results
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pidc_pkg::DATA_W-1:0]  rsp_drive,
   output logic                         rsp_integ_clamped,
   output logic                         rsp_drive_clamped
);

   pidc_pkg::cfg_type            cfg;

   // input register
   logic                         in_valid_ff;
   logic [pidc_pkg::DATA_W-1:0]  in_meas_ff;
   logic                         in_ready;

   // stage handshakes
   logic                         front_ready;
   logic                         front_valid;
   pidc_pkg::front_type          front_data;
   logic                         mult_ready;
   logic                         mult_valid;
   pidc_pkg::prod_type           mult_data;
   logic                         out_ready;

   pidc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register: free when empty or when its word moves on
   assign in_ready  = !in_valid_ff || front_ready;
   assign req_stall = !in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_ready) begin
         in_meas_ff <= req_measured_position;
      end
   end

   pidc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_ready  (front_ready),
      .in_meas   (in_meas_ff),
      .out_valid (front_valid),
      .out_ready (mult_ready),
      .out_data  (front_data)
   );

   pidc_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (front_valid),
      .in_ready  (mult_ready),
      .in_data   (front_data),
      .out_valid (mult_valid),
      .out_ready (out_ready),
      .out_data  (mult_data)
   );

   pidc_out u_out (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .in_valid          (mult_valid),
      .in_ready          (out_ready),
      .in_data           (mult_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive         (rsp_drive),
      .rsp_integ_clamped (rsp_integ_clamped),
      .rsp_drive_clamped (rsp_drive_clamped)
   );

`ifndef SYNTH
   // the input register only refuses a word while it holds one
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with an empty input register");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

   // one result word as it leaves the block
   typedef struct packed {
      logic [pidc_pkg::DATA_W-1:0] drive;
      logic                        integ_clamped;
      logic                        drive_clamped;
   } drive_word_type;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   // one step of the directed plan: a register write or a position sample
   typedef struct packed {
      row_kind_type                kind;
      logic [pidc_pkg::IDX_W-1:0]  index;   // register rows only
      logic [pidc_pkg::DATA_W-1:0] value;   // sample or register data
      logic                        typed;   // word below is the known answer
      drive_word_type              word;
   } plan_row_type;

   localparam int PLAN_LEN = 34;

   // Directed plan. Known answers are only typed in where they fall out by hand:
   // right after reset, at the clamp extremes, at the rounding ties and with
   // crossed bounds. Everything else goes through the predictor.
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // reset defaults: on setpoint from rest, derivative kick pins drive low
      '{ROW_SAMPLE, '0, 16'd25600, 1'b1, '{16'h0000, 1'b0, 1'b1}},
      // on setpoint, nothing moving: drive sits exactly on the lower bound
      '{ROW_SAMPLE, '0, 16'd25600, 1'b1, '{16'h0000, 1'b0, 1'b0}},
      // full-scale swings saturate both integrator and drive
      '{ROW_SAMPLE, '0, 16'h8000,  1'b1, '{16'h0A00, 1'b1, 1'b1}},
      '{ROW_SAMPLE, '0, 16'h7FFF,  1'b1, '{16'h0000, 1'b1, 1'b1}},
      '{ROW_SAMPLE, '0, 16'h0000,  1'b0, '0},
      // pure P path with gain 1 LSB and open drive range: rounding ties
      '{ROW_CSR, pidc_pkg::REG_GAIN_P,      16'h0001, 1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_GAIN_I,      16'h0000, 1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_GAIN_D,      16'h0000, 1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_DRIVE_UPPER, 16'h7FFF, 1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_DRIVE_LOWER, 16'h8000, 1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_SETPOINT,    16'h0000, 1'b0, '0},
      '{ROW_SAMPLE, '0, 16'hFF80,  1'b1, '{16'h0001, 1'b1, 1'b0}},  // +half LSB rounds up
      '{ROW_SAMPLE, '0, 16'h0080,  1'b1, '{16'h0000, 1'b0, 1'b0}},  // -half LSB rounds up to 0
      '{ROW_SAMPLE, '0, 16'h0081,  1'b1, '{16'hFFFF, 1'b0, 1'b0}},  // just past the tie
      // all gains at max, widest integrator range
      '{ROW_CSR, pidc_pkg::REG_GAIN_P,      16'hFFFF, 1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_GAIN_I,      16'hFFFF, 1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_GAIN_D,      16'hFFFF, 1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_SETPOINT,    16'h7FFF, 1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_INTEG_UPPER, 16'h7FFF, 1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_INTEG_LOWER, 16'h8000, 1'b0, '0},
      '{ROW_SAMPLE, '0, 16'h8000,  1'b0, '0},
      '{ROW_SAMPLE, '0, 16'h7FFF,  1'b0, '0},
      '{ROW_SAMPLE, '0, 16'h8000,  1'b0, '0},
      '{ROW_SAMPLE, '0, 16'h0000,  1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_SETPOINT,    16'h8000, 1'b0, '0},
      '{ROW_SAMPLE, '0, 16'h7FFF,  1'b0, '0},
      '{ROW_SAMPLE, '0, 16'h8000,  1'b0, '0},
      // crossed bounds: upper applied first, so everything lands on lower
      '{ROW_CSR, pidc_pkg::REG_INTEG_UPPER, 16'h8000, 1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_INTEG_LOWER, 16'h7FFF, 1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_DRIVE_UPPER, 16'h8000, 1'b0, '0},
      '{ROW_CSR, pidc_pkg::REG_DRIVE_LOWER, 16'h7FFF, 1'b0, '0},
      '{ROW_SAMPLE, '0, 16'h0000,  1'b1, '{16'h7FFF, 1'b1, 1'b1}},
      '{ROW_SAMPLE, '0, 16'h5A5A,  1'b1, '{16'h7FFF, 1'b1, 1'b1}},
      '{ROW_SAMPLE, '0, 16'hA5A5,  1'b0, '0}
   };

   // every input starts at a known value
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wen = 1'b0;
   logic [pidc_pkg::IDX_W-1:0]  csr_index = '0;
   logic [pidc_pkg::DATA_W-1:0] csr_wdata = '0;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [pidc_pkg::DATA_W-1:0] req_measured_position = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [pidc_pkg::DATA_W-1:0] rsp_drive;
   logic                        rsp_integ_clamped;
   logic                        rsp_drive_clamped;

   // predictor copy of the registers and loop state
   pidc_pkg::cfg_type                  ctl;
   logic signed [pidc_pkg::DATA_W-1:0] integ_state;
   logic signed [pidc_pkg::DATA_W-1:0] last_position;

   drive_word_type drives_due[$];   // answers in order of acceptance
   int unsigned    mismatches = 0;
   bit             steady_flow = 1'b0; // both sides run without gaps

   pid_controller_clamped uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // One regulator step: error, clamped integrator, derivative on measurement,
   // exact wide sum, round half up to Q8.8, then the drive clamp.
   function automatic drive_word_type next_drive(
      input logic signed [pidc_pkg::DATA_W-1:0] pos);
      longint         err, deriv, isum, acc, drv;
      drive_word_type w;
      err   = longint'($signed(ctl.setpoint)) - longint'(pos);
      deriv = longint'(pos) - longint'(last_position);
      w.integ_clamped = 1'b0;
      w.drive_clamped = 1'b0;
      isum = longint'(integ_state) + err;
      // upper bound first, then lower against the result
      if (isum > longint'($signed(ctl.integ_upper))) begin
         isum = longint'($signed(ctl.integ_upper));
         w.integ_clamped = 1'b1;
      end
      if (isum < longint'($signed(ctl.integ_lower))) begin
         isum = longint'($signed(ctl.integ_lower));
         w.integ_clamped = 1'b1;
      end
      integ_state = isum[pidc_pkg::DATA_W-1:0];
      acc = longint'(ctl.gain_p) * err + longint'(ctl.gain_i) * longint'(integ_state)
          - longint'(ctl.gain_d) * deriv;
      // arithmetic shift is a floor, so ties go toward plus infinity
      drv = (acc + longint'(pidc_pkg::ROUND_BIAS)) >>> pidc_pkg::FRAC_W;
      if (drv > longint'($signed(ctl.drive_upper))) begin
         drv = longint'($signed(ctl.drive_upper));
         w.drive_clamped = 1'b1;
      end
      if (drv < longint'($signed(ctl.drive_lower))) begin
         drv = longint'($signed(ctl.drive_lower));
         w.drive_clamped = 1'b1;
      end
      w.drive = drv[pidc_pkg::DATA_W-1:0];
      last_position = pos;
      return w;
   endfunction

   function automatic int draw_pause();
      return steady_flow ? 0 : int'($urandom_range(0, 5));
   endfunction

   // gains lean small so the loop does something useful, with both extremes
   function automatic logic [pidc_pkg::DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return pidc_pkg::DATA_W'($urandom());
         default: return pidc_pkg::DATA_W'($urandom_range(0, 1023));
      endcase
   endfunction

   task automatic report_mismatch(input string field,
                                  input logic [pidc_pkg::DATA_W-1:0] want,
                                  input logic [pidc_pkg::DATA_W-1:0] got);
      $display("%0t: %s expected %h got %h", $time, field, want, got);
      mismatches++;
   endtask

   // Present one sample after a random gap and hold it until taken. The
   // predictor advances on the accepting edge.
   task automatic send_position(input logic [pidc_pkg::DATA_W-1:0] pos,
                                input logic typed, input drive_word_type known);
      int             pause;
      drive_word_type want;
      pause = draw_pause();
      @(negedge clock);
      if (pause > 0) begin
         req_valid = 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_valid             = 1'b1;
      req_measured_position = pos;
      do @(posedge clock); while (req_stall);
      want = next_drive(pos);
      drives_due.push_back(typed ? known : want);
   endtask

   // drop valid and wait until every pending word is back
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (drives_due.size() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   // register write, mirrored into the predictor copy
   task automatic write_reg(input logic [pidc_pkg::IDX_W-1:0] idx,
                            input logic [pidc_pkg::DATA_W-1:0] val);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wen = 1'b0;
      case (idx)
         pidc_pkg::REG_SETPOINT:    ctl.setpoint    = val;
         pidc_pkg::REG_GAIN_P:      ctl.gain_p      = val;
         pidc_pkg::REG_GAIN_I:      ctl.gain_i      = val;
         pidc_pkg::REG_GAIN_D:      ctl.gain_d      = val;
         pidc_pkg::REG_INTEG_UPPER: ctl.integ_upper = val;
         pidc_pkg::REG_INTEG_LOWER: ctl.integ_lower = val;
         pidc_pkg::REG_DRIVE_UPPER: ctl.drive_upper = val;
         pidc_pkg::REG_DRIVE_LOWER: ctl.drive_lower = val;
      endcase
   endtask

   // Result side: random stall before each word, then compare against the
   // oldest pending answer.
   initial begin : collect_drives
      int             hold;
      drive_word_type want;
      wait (reset == 1'b0);
      forever begin
         hold = draw_pause();
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (drives_due.size() == 0) begin
            report_mismatch("word with nothing pending, drive", '0, rsp_drive);
         end else begin
            want = drives_due.pop_front();
            if (rsp_drive !== want.drive) begin
               report_mismatch("drive", want.drive, rsp_drive);
            end
            if (rsp_integ_clamped !== want.integ_clamped) begin
               report_mismatch("integ_clamped", pidc_pkg::DATA_W'(want.integ_clamped),
                               pidc_pkg::DATA_W'(rsp_integ_clamped));
            end
            if (rsp_drive_clamped !== want.drive_clamped) begin
               report_mismatch("drive_clamped", pidc_pkg::DATA_W'(want.drive_clamped),
                               pidc_pkg::DATA_W'(rsp_drive_clamped));
            end
         end
      end
   end

   initial begin : stimulus
      int                                 style, walk, pos;
      logic signed [pidc_pkg::DATA_W-1:0] hi_v, lo_v, t16;
      ctl = '{pidc_pkg::SETPOINT_RST, pidc_pkg::GAIN_P_RST, pidc_pkg::GAIN_I_RST,
              pidc_pkg::GAIN_D_RST, pidc_pkg::INTEG_UPPER_RST, pidc_pkg::INTEG_LOWER_RST,
              pidc_pkg::DRIVE_UPPER_RST, pidc_pkg::DRIVE_LOWER_RST};
      integ_state   = '0;
      last_position = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed plan; register writes only once the pipe is empty
      for (int r = 0; r < PLAN_LEN; r++) begin
         if (PLAN[r].kind == ROW_CSR) begin
            wait_idle();
            write_reg(PLAN[r].index, PLAN[r].value);
         end else begin
            send_position(PLAN[r].value, PLAN[r].typed, PLAN[r].word);
         end
      end

      // Random phases: fresh settings each time, then a run of samples. Phase
      // styles: uniform noise, jitter around the setpoint, a random walk that
      // drags the integrator into its limits, and a mix of noise and jitter.
      for (int phase = 0; phase < 10; phase++) begin
         wait_idle();
         steady_flow = (phase % 3 == 2);
         case ($urandom_range(0, 5))
            0: write_reg(pidc_pkg::REG_SETPOINT, 16'h7FFF);
            1: write_reg(pidc_pkg::REG_SETPOINT, 16'h8000);
            default: write_reg(pidc_pkg::REG_SETPOINT, pidc_pkg::DATA_W'($urandom()));
         endcase
         write_reg(pidc_pkg::REG_GAIN_P, pick_gain());
         write_reg(pidc_pkg::REG_GAIN_I, pick_gain());
         write_reg(pidc_pkg::REG_GAIN_D, pick_gain());
         // integrator pair, then drive pair
         for (int b = 0; b < 2; b++) begin
            hi_v = pidc_pkg::DATA_W'($urandom());
            lo_v = pidc_pkg::DATA_W'($urandom());
            case ($urandom_range(0, 7))
               0: begin
                  hi_v = 16'sh7FFF;
                  lo_v = 16'sh8000;
               end
               1: lo_v = hi_v;               // zero-width window
               2: begin                      // crossed bounds
                  if (lo_v < hi_v) begin
                     t16  = lo_v;
                     lo_v = hi_v;
                     hi_v = t16;
                  end
               end
               3, 4: begin                   // narrow window around zero
                  hi_v = pidc_pkg::DATA_W'($urandom_range(0, 4096));
                  lo_v = pidc_pkg::DATA_W'(-int'($urandom_range(0, 4096)));
               end
               default: begin
                  if (lo_v > hi_v) begin
                     t16  = lo_v;
                     lo_v = hi_v;
                     hi_v = t16;
                  end
               end
            endcase
            write_reg(b ? pidc_pkg::REG_DRIVE_UPPER : pidc_pkg::REG_INTEG_UPPER, hi_v);
            write_reg(b ? pidc_pkg::REG_DRIVE_LOWER : pidc_pkg::REG_INTEG_LOWER, lo_v);
         end

         style = phase % 4;
         walk  = int'($signed(ctl.setpoint));
         for (int i = 0; i < 70; i++) begin
            if (style == 0 || (style == 3 && $urandom_range(0, 3) == 0)) begin
               pos = int'($signed(pidc_pkg::DATA_W'($urandom())));
            end else if (style == 2) begin
               pos = walk + int'($urandom_range(0, 512)) - 256;
            end else begin
               pos = int'($signed(ctl.setpoint)) + int'($urandom_range(0, 1024)) - 512;
            end
            if (pos > 32767) begin
               pos = 32767;
            end
            if (pos < -32768) begin
               pos = -32768;
            end
            walk = pos;
            send_position(pidc_pkg::DATA_W'(pos), 1'b0, '0);
         end
      end

      steady_flow = 1'b0;
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
